// ===== src/cnv3_pkg.sv =====
// Shared types, constants and helpers for the 3x3 convolution block.
`default_nettype none
package cnv3_pkg;

	// Geometry defaults for the top-level parameters
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// Fixed field widths
	localparam int PIX_W     = 8;
	localparam int DIM_W     = 12;
	localparam int TAP_W     = 12;
	localparam int TAPS      = 3;
	localparam int KROW_W    = TAP_W * TAPS;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = KROW_W;
	localparam int POS_W     = 11;
	localparam int WIN_N     = 9;
	localparam int MIN_DIM   = 3;
	localparam int PIX_MAX   = 255;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_KERNEL_TOP   = 3'd2,
		REG_KERNEL_MID   = 3'd3,
		REG_KERNEL_BOT   = 3'd4,
		REG_ABS_MODE     = 3'd5
	} cfg_reg_t;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [KROW_W-1:0] krow_t;
	// Window, row-major: index 0 is top-left, 8 is bottom-right
	typedef pix_t [WIN_N-1:0]  win_t;

	// Signed Q3.8 tap k of a kernel row; left tap in the low bits
	function automatic logic signed [TAP_W-1:0] tap_of(krow_t row, int unsigned k);
		return $signed(row[k*TAP_W +: TAP_W]);
	endfunction

endpackage
`default_nettype wire

// ===== src/cnv3_line_buf.sv =====
// Two line stores packed into one memory: each entry holds {upper, lower} pixels.
`default_nettype none
module cnv3_line_buf #(
	parameter int DEPTH = cnv3_pkg::DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [2*cnv3_pkg::PIX_W-1:0] rd_data_s1,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [2*cnv3_pkg::PIX_W-1:0] wr_data
);
	import cnv3_pkg::*;

	logic [2*PIX_W-1:0] mem [DEPTH];

	// One registered read port, one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// ===== src/cnv3_window.sv =====
// 3x3 pixel window: shifts left one column per beat, new column enters at the right.
`default_nettype none
module cnv3_window (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire cnv3_pkg::pix_t col_top,
	input  wire cnv3_pkg::pix_t col_mid,
	input  wire cnv3_pkg::pix_t col_bot,
	output cnv3_pkg::win_t     win_s2
);
	import cnv3_pkg::*;

	pix_t new_col [3];

	assign new_col[0] = col_top;
	assign new_col[1] = col_mid;
	assign new_col[2] = col_bot;

	// Shift each row left, load the incoming column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				win_s2[i*3]     <= win_s2[i*3 + 1];
				win_s2[i*3 + 1] <= win_s2[i*3 + 2];
				win_s2[i*3 + 2] <= new_col[i];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/cnv3_filter.sv =====
// Nine-tap multiply, row sums, then round half up and clamp or saturate.
`default_nettype none
module cnv3_filter (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire cnv3_pkg::win_t  win,
	input  wire cnv3_pkg::krow_t k_top,
	input  wire cnv3_pkg::krow_t k_mid,
	input  wire cnv3_pkg::krow_t k_bot,
	input  wire logic            abs_mode,
	output cnv3_pkg::pix_t       value
);
	import cnv3_pkg::*;

	localparam int PROD_W = PIX_W + 1 + TAP_W;
	localparam int ROW_W  = PROD_W + 2;
	localparam int SUM_W  = ROW_W + 2;
	localparam int RES_W  = SUM_W - 8;

	krow_t                    krows [3];
	logic signed [PROD_W-1:0] prod_s3 [WIN_N];
	logic signed [ROW_W-1:0]  row_sum_s4 [3];
	logic signed [SUM_W-1:0]  total;
	logic signed [SUM_W-1:0]  rounded;
	logic signed [RES_W-1:0]  res;
	logic signed [RES_W-1:0]  mag;

	assign krows[0] = k_top;
	assign krows[1] = k_mid;
	assign krows[2] = k_bot;

	// Stage 3: one product per tap, pixel zero-extended to signed
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s3[i*3 + j] <= PROD_W'($signed({1'b0, win[i*3 + j]}))
						* PROD_W'(tap_of(krows[i], j));
				end
			end
		end
	end

	// Stage 4: per-row sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				row_sum_s4[i] <= ROW_W'(prod_s3[i*3]) + ROW_W'(prod_s3[i*3 + 1])
					+ ROW_W'(prod_s3[i*3 + 2]);
			end
		end
	end

	// Final sum, round half up (floor of sum + 1/2), then clamp or abs-saturate
	always_comb begin
		total   = SUM_W'(row_sum_s4[0]) + SUM_W'(row_sum_s4[1]) + SUM_W'(row_sum_s4[2]);
		rounded = total + SUM_W'(128);
		res     = rounded[SUM_W-1:8];
		if (res < 0) begin
			mag = abs_mode ? -res : '0;
		end else begin
			mag = res;
		end
		if (mag > RES_W'(PIX_MAX)) begin
			value = PIX_W'(PIX_MAX);
		end else begin
			value = mag[PIX_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== src/conv3x3_saturating.sv =====
// Top level: streaming 3x3 convolution with line stores and programmable Q3.8 taps.
//
//   channel | signals                                      | dir | beat
//   --------+----------------------------------------------+-----+---------------------------
//   in      | in_valid, in_stall, pixel                    | in  | one raster-order pixel
//   out     | out_valid, out_stall, value, out_row,        | out | one interior result
//           | out_column, frame_done                       |     |
//   cfg     | cfg_we, cfg_index, cfg_data                  | in  | one register write
//
// One pixel per cycle sustained while no result is held; each result is registered through
// the line-store read, window, products, row sums and output register, in that order.
// The pipeline advances as a whole; a stalled output holds every stage and in_stall.
// Reset clears the counters and stage valids and resets the configuration; line stores and
// window are not cleared and hold garbage until the first rows pass through.
`default_nettype none
module conv3x3_saturating #(
	parameter int MAX_WIDTH  = cnv3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cnv3_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input pixels
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [cnv3_pkg::PIX_W-1:0]     pixel,
	// Results
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [cnv3_pkg::PIX_W-1:0]     value,
	output logic      [cnv3_pkg::POS_W-1:0]     out_row,
	output logic      [cnv3_pkg::POS_W-1:0]     out_column,
	output logic                                frame_done,
	// Configuration
	input  wire logic                           cfg_we,
	input  wire logic [cnv3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cnv3_pkg::CFG_W-1:0]     cfg_data
);
	import cnv3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	typedef struct packed {
		logic             emit;
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} meta_t;

	// Configuration registers
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	krow_t            k_top_q;
	krow_t            k_mid_q;
	krow_t            k_bot_q;
	logic             abs_mode_q;

	// Position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic          last_col;
	logic          last_row;

	// Pipeline
	logic              adv;
	logic              in_acc;
	logic              valid_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic              vld_s4;
	meta_t             meta_s1;
	meta_t             meta_s2;
	meta_t             meta_s3;
	meta_t             meta_s4;
	logic [CW-1:0]     addr_s1;
	pix_t              pixel_s1;
	logic [2*PIX_W-1:0] rd_data_s1;
	logic              lb_wr_en;
	win_t              win_s2;
	pix_t              filt_value;
	logic              out_valid_q;
	pix_t              value_q;
	logic [POS_W-1:0]  out_row_q;
	logic [POS_W-1:0]  out_col_q;
	logic              frame_done_q;

	// Configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(2048);
			image_height_q <= DIM_W'(2048);
			k_top_q        <= '0;
			k_mid_q        <= '0;
			k_bot_q        <= '0;
			abs_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				REG_KERNEL_TOP:   k_top_q        <= cfg_data[KROW_W-1:0];
				REG_KERNEL_MID:   k_mid_q        <= cfg_data[KROW_W-1:0];
				REG_KERNEL_BOT:   k_bot_q        <= cfg_data[KROW_W-1:0];
				REG_ABS_MODE:     abs_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Last column / row index, geometry clamped to 3..max
	always_comb begin
		if (image_width_q < DIM_W'(MIN_DIM)) begin
			col_last = CW'(MIN_DIM - 1);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(image_width_q - DIM_W'(1));
		end
		if (image_height_q < DIM_W'(MIN_DIM)) begin
			row_last = RW'(MIN_DIM - 1);
		end else if (int'(image_height_q) > MAX_HEIGHT) begin
			row_last = RW'(MAX_HEIGHT - 1);
		end else begin
			row_last = RW'(image_height_q - DIM_W'(1));
		end
	end

	assign last_col = col_q >= col_last;
	assign last_row = row_q >= row_last;

	// Handshake: the whole pipeline moves unless a result is held
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// Raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: line-store read, beat metadata
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1      <= col_q;
			pixel_s1     <= pixel;
			meta_s1.emit <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			meta_s1.last <= last_row && last_col;
			meta_s1.row  <= POS_W'(row_q - RW'(1));
			meta_s1.col  <= POS_W'(col_q - CW'(1));
		end
	end

	assign lb_wr_en = adv && valid_s1;

	cnv3_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk        (clk),
		.rd_en      (in_acc),
		.rd_addr    (col_q),
		.rd_data_s1 (rd_data_s1),
		.wr_en      (lb_wr_en),
		.wr_addr    (addr_s1),
		.wr_data    ({rd_data_s1[PIX_W-1:0], pixel_s1})
	);

	// Stage 2: window
	cnv3_window u_window (
		.clk     (clk),
		.en      (lb_wr_en),
		.col_top (rd_data_s1[2*PIX_W-1:PIX_W]),
		.col_mid (rd_data_s1[PIX_W-1:0]),
		.col_bot (pixel_s1),
		.win_s2  (win_s2)
	);

	// Stages 3 and 4 live in the filter; output register follows
	cnv3_filter u_filter (
		.clk      (clk),
		.en       (adv),
		.win      (win_s2),
		.k_top    (k_top_q),
		.k_mid    (k_mid_q),
		.k_bot    (k_bot_q),
		.abs_mode (abs_mode_q),
		.value    (filt_value)
	);

	// Valid chain: only interior beats travel past stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s2      <= valid_s1 && meta_s1.emit;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2      <= meta_s1;
			meta_s3      <= meta_s2;
			meta_s4      <= meta_s3;
			value_q      <= filt_value;
			out_row_q    <= meta_s4.row;
			out_col_q    <= meta_s4.col;
			frame_done_q <= meta_s4.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign out_row    = out_row_q;
	assign out_column = out_col_q;
	assign frame_done = frame_done_q;

`ifndef SYNTH
	// The store is never written and read at the same address in one cycle
	a_lb_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		lb_wr_en && in_acc |-> addr_s1 != col_q)
		else $error("line store read and write collide");

	// End of frame wraps both counters
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_col && last_row |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap at end of frame");

	// Results only for interior pixels
	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_row != '0 && out_column != '0)
		else $error("border pixel emitted");
`endif

endmodule
`default_nettype wire

// ===== sim/conv3x3_saturating_tb.sv =====
// Self-checking testbench for the streaming 3x3 convolution block, with a pixel-level predictor.
module conv3x3_saturating_tb;
	import cnv3_pkg::*;

	localparam int LINE_MAX        = DEF_MAX_WIDTH;
	localparam int ROWS_MAX        = DEF_MAX_HEIGHT;
	localparam int PIPE_LATENCY    = 5;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_PIXELS   = 800;

	// Indexes past the last register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic MODE_CLAMP = 1'b0;
	localparam logic MODE_ABS   = 1'b1;

	localparam logic signed [TAP_W-1:0] TAP_MAX_POS  = 12'sh7FF;
	localparam logic signed [TAP_W-1:0] TAP_MAX_NEG  = 12'sh800;
	localparam logic signed [TAP_W-1:0] TAP_TIE      = 12'sd5;
	localparam pix_t                    PIX_HALF     = 8'd128;

	typedef struct packed {
		pix_t             value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} filt_result_t;

	// DUT signals
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	pix_t                 pixel = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	pix_t                 value;
	logic [POS_W-1:0]     out_row;
	logic [POS_W-1:0]     out_column;
	logic                 frame_done;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Predictor copy of registers and state
	logic [DIM_W-1:0] width_reg = DIM_W'(DEF_MAX_WIDTH);
	logic [DIM_W-1:0] height_reg = DIM_W'(DEF_MAX_HEIGHT);
	krow_t            kernel_rows [3] = '{default: '0};
	logic             abs_mode = MODE_CLAMP;
	pix_t             upper_line [LINE_MAX] = '{default: '0};
	pix_t             lower_line [LINE_MAX] = '{default: '0};
	pix_t             window [WIN_N] = '{default: '0};
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;
	filt_result_t     expected_q [$];

	// Bookkeeping
	int  errors = 0;
	int  pixels_sent = 0;
	int  results_seen = 0;
	int  frames_done = 0;
	int  quiet_cycles = 0;
	int  holds_asked = 0;
	int  holds_served = 0;
	int  hold_left = 0;
	bit  calm = 1'b0;

	conv3x3_saturating uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.out_row   (out_row),
		.out_column(out_column),
		.frame_done(frame_done),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Geometry as the block sees it: below 3 acts as 3, above the maximum acts as the maximum
	function automatic int unsigned effective_dim(logic [DIM_W-1:0] raw, int unsigned top);
		if (raw < MIN_DIM) return MIN_DIM;
		if (raw > top) return top;
		return raw;
	endfunction

	// Dimension register word with junk in the unused upper bits
	function automatic logic [CFG_W-1:0] dim_word(int unsigned raw);
		logic [CFG_W-1:0] w;
		w = CFG_W'({$urandom, $urandom});
		w[DIM_W-1:0] = DIM_W'(raw);
		return w;
	endfunction

	// Mostly taps within +-1.0 so results spread out; sometimes any 36-bit pattern
	function automatic krow_t random_krow();
		krow_t k;
		int t;
		if ($urandom_range(3) == 0) begin
			k = krow_t'({$urandom, $urandom});
		end else begin
			for (t = 0; t < TAPS; t++)
				k[TAP_W*t +: TAP_W] = TAP_W'($urandom_range(512) - 256);
		end
		return k;
	endfunction

	// Advance the predictor by one pixel beat and queue the result it causes, if any
	function automatic void predict_pixel(pix_t px);
		int unsigned w, h, slot;
		bit end_col, end_row;
		int i, j, acc, rounded;
		logic signed [TAP_W-1:0] tap;
		filt_result_t res;
		w = effective_dim(width_reg, LINE_MAX);
		h = effective_dim(height_reg, ROWS_MAX);
		slot = (col_pos < LINE_MAX) ? col_pos : LINE_MAX - 1;
		end_col = col_pos >= w - 1;
		end_row = row_pos >= h - 1;

		// shift window left, load new right column from the line stores
		for (i = 0; i < 3; i++) begin
			window[3*i]   = window[3*i+1];
			window[3*i+1] = window[3*i+2];
		end
		window[2] = upper_line[slot];
		window[5] = lower_line[slot];
		window[8] = px;
		upper_line[slot] = lower_line[slot];
		lower_line[slot] = px;

		if (row_pos >= 2 && col_pos >= 2) begin
			// exact sum in 1/256 units, round half up, then clamp or take magnitude
			acc = 0;
			for (i = 0; i < 3; i++)
				for (j = 0; j < TAPS; j++) begin
					tap = kernel_rows[i][TAP_W*j +: TAP_W];
					acc += int'(window[3*i+j]) * int'(tap);
				end
			rounded = (acc + 128) >>> 8;
			if (rounded < 0) rounded = abs_mode ? -rounded : 0;
			res.value = (rounded > PIX_MAX) ? pix_t'(PIX_MAX) : pix_t'(rounded);
			res.row   = POS_W'(row_pos - 1);
			res.col   = POS_W'(col_pos - 1);
			res.done  = end_row && end_col;
			expected_q.push_back(res);
		end

		if (end_col) begin
			col_pos = 0;
			if (end_row) begin
				row_pos = 0;
				frames_done++;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
	endfunction

	task automatic report_mismatch(string what, int want_v, int got_v);
		$display("MISMATCH %s: expected %0d, got %0d (t=%0t)", what, want_v, got_v, $time);
		errors++;
	endtask

	// Register write; the enable is dropped again before the task returns, so it never toggles twice in one step
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg = data[DIM_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
			REG_KERNEL_TOP:   kernel_rows[0] = data[KROW_W-1:0];
			REG_KERNEL_MID:   kernel_rows[1] = data[KROW_W-1:0];
			REG_KERNEL_BOT:   kernel_rows[2] = data[KROW_W-1:0];
			REG_ABS_MODE:     abs_mode = data[0];
			default: ;
		endcase
	endtask

	// One input beat; valid stays high for a following beat unless a gap is drawn
	task automatic send_pixel(pix_t px);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= px;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
		predict_pixel(px);
	endtask

	// Send random pixels until the frame counters wrap
	task automatic finish_frame();
		do send_pixel(pix_t'($urandom)); while (col_pos != 0 || row_pos != 0);
	endtask

	// Stop sending, let every expected result out, then let the pipeline empty
	task automatic wait_idle();
		int settled;
		settled = 0;
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		while (settled < PIPE_LATENCY + 3) begin
			@(posedge clk);
			if (!out_stall) settled++;
		end
	endtask

	// Long rows, first in clamp mode, then in magnitude mode
	task automatic test_wide_rows();
		write_reg(REG_KERNEL_TOP, random_krow());
		write_reg(REG_KERNEL_MID, random_krow());
		write_reg(REG_KERNEL_BOT, random_krow());
		write_reg(REG_IMAGE_WIDTH, dim_word(150));
		write_reg(REG_IMAGE_HEIGHT, dim_word(MIN_DIM));
		finish_frame();
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, dim_word(61));
		write_reg(REG_ABS_MODE, CFG_W'(MODE_ABS));
		finish_frame();
		wait_idle();
	endtask

	// Narrowest rows over a tall frame; a width below 3 acts as 3
	task automatic test_tall_frame();
		write_reg(REG_IMAGE_WIDTH, dim_word(2));
		write_reg(REG_IMAGE_HEIGHT, dim_word(40));
		write_reg(REG_ABS_MODE, CFG_W'(MODE_CLAMP));
		finish_frame();
		wait_idle();
	endtask

	// Sums of exactly -2.5 and +2.5: magnitude mode gives 2 and 3, clamp mode 0 and 3
	task automatic test_rounding_ties();
		logic modes [2];
		int m;
		modes[0] = MODE_ABS;
		modes[1] = MODE_CLAMP;
		write_reg(REG_IMAGE_WIDTH, dim_word(4));
		write_reg(REG_IMAGE_HEIGHT, dim_word(MIN_DIM));
		write_reg(REG_KERNEL_TOP, '0);
		write_reg(REG_KERNEL_BOT, '0);
		write_reg(REG_KERNEL_MID, {TAP_TIE, -TAP_TIE, TAP_W'(0)});
		for (m = 0; m < 2; m++) begin
			write_reg(REG_ABS_MODE, CFG_W'(modes[m]));
			repeat (5) send_pixel(pix_t'($urandom));
			send_pixel(PIX_HALF);
			send_pixel('0);
			send_pixel(PIX_HALF);
			repeat (4) send_pixel(pix_t'($urandom));
			wait_idle();
		end
	endtask

	// Extreme taps on full-scale pixels: positive taps in clamp mode, negative taps in both modes
	task automatic test_saturation();
		write_reg(REG_IMAGE_WIDTH, dim_word(MIN_DIM));
		write_reg(REG_IMAGE_HEIGHT, dim_word(MIN_DIM));
		write_reg(REG_KERNEL_TOP, {3{TAP_MAX_POS}});
		write_reg(REG_KERNEL_MID, {3{TAP_MAX_POS}});
		write_reg(REG_KERNEL_BOT, {3{TAP_MAX_POS}});
		write_reg(REG_ABS_MODE, CFG_W'(MODE_CLAMP));
		repeat (9) send_pixel(pix_t'(PIX_MAX));
		wait_idle();
		write_reg(REG_KERNEL_TOP, {3{TAP_MAX_NEG}});
		write_reg(REG_KERNEL_MID, {3{TAP_MAX_NEG}});
		write_reg(REG_KERNEL_BOT, {3{TAP_MAX_NEG}});
		repeat (9) send_pixel(pix_t'(PIX_MAX));
		wait_idle();
		write_reg(REG_ABS_MODE, CFG_W'(MODE_ABS));
		repeat (9) send_pixel(pix_t'(PIX_MAX));
		wait_idle();
	endtask

	// Dimensions below 3, and writes to unused indexes that must change nothing
	task automatic test_geometry_clamp();
		write_reg(REG_KERNEL_MID, random_krow());
		write_reg(REG_IMAGE_WIDTH, dim_word(0));
		write_reg(REG_IMAGE_HEIGHT, dim_word(1));
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		finish_frame();
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, dim_word(1));
		write_reg(REG_IMAGE_HEIGHT, dim_word(0));
		write_reg(REG_SPARE_HI, CFG_W'({$urandom, $urandom}));
		finish_frame();
		wait_idle();
	endtask

	// Shrink width past the current column, then height past the current row
	task automatic test_midframe_resize();
		write_reg(REG_IMAGE_WIDTH, dim_word(10));
		write_reg(REG_IMAGE_HEIGHT, dim_word(8));
		write_reg(REG_KERNEL_TOP, random_krow());
		write_reg(REG_KERNEL_BOT, random_krow());
		repeat (37) send_pixel(pix_t'($urandom));   // three rows and seven columns in
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, dim_word(5));
		while (!(row_pos == 5 && col_pos == 2)) send_pixel(pix_t'($urandom));
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, dim_word(4));
		write_reg(REG_KERNEL_MID, random_krow());
		finish_frame();
		wait_idle();
	endtask

	// Random frames with random settings, mid-frame pauses and one long output hold
	task automatic test_random_frames();
		int start;
		int frame_no;
		int unsigned cur;
		start = pixels_sent;
		frame_no = 0;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			calm = (frame_no >= 5 && frame_no < 10);
			if (frame_no == 0 || $urandom_range(1))
				write_reg(REG_IMAGE_WIDTH, dim_word(($urandom_range(9) == 0) ?
					$urandom_range(2) : $urandom_range(3, 16)));
			if (frame_no == 0 || $urandom_range(1))
				write_reg(REG_IMAGE_HEIGHT, dim_word(($urandom_range(9) == 0) ?
					$urandom_range(2) : $urandom_range(3, 10)));
			if (frame_no == 0 || $urandom_range(1)) write_reg(REG_KERNEL_TOP, random_krow());
			if (frame_no == 0 || $urandom_range(1)) write_reg(REG_KERNEL_MID, random_krow());
			if (frame_no == 0 || $urandom_range(1)) write_reg(REG_KERNEL_BOT, random_krow());
			if (frame_no == 0 || $urandom_range(1))
				write_reg(REG_ABS_MODE, CFG_W'($urandom_range(1)));
			if (frame_no == 4) holds_asked++;
			do begin
				send_pixel(pix_t'($urandom));
				if ($urandom_range(99) == 0 && (col_pos != 0 || row_pos != 0)) begin
					// sender pause until drained, then maybe retune or shrink
					wait_idle();
					if ($urandom_range(1)) write_reg(REG_KERNEL_MID, random_krow());
					if ($urandom_range(1)) write_reg(REG_ABS_MODE, CFG_W'($urandom_range(1)));
					if ($urandom_range(3) == 0) begin
						cur = effective_dim(width_reg, LINE_MAX);
						write_reg(REG_IMAGE_WIDTH, dim_word($urandom_range(MIN_DIM, cur)));
					end
					if ($urandom_range(3) == 0) begin
						cur = effective_dim(height_reg, ROWS_MAX);
						write_reg(REG_IMAGE_HEIGHT, dim_word($urandom_range(MIN_DIM, cur)));
					end
				end
			end while (col_pos != 0 || row_pos != 0);
			wait_idle();
			frame_no++;
		end
		calm = 1'b0;
	endtask

	// Result checker and output stall driver
	always @(posedge clk) begin
		filt_result_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch("result with none pending, value", -1, value);
			end else begin
				want = expected_q.pop_front();
				if (value !== want.value) report_mismatch("value", want.value, value);
				if (out_row !== want.row) report_mismatch("out_row", want.row, out_row);
				if (out_column !== want.col) report_mismatch("out_column", want.col, out_column);
				if (frame_done !== want.done)
					report_mismatch("frame_done", want.done, frame_done);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_served < holds_asked) begin
			holds_served++;
			hold_left = HOLD_OFF_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 8);
		end
	end

	// Watchdog on cycles without any beat or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results pending",
				quiet_cycles, expected_q.size());
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Test sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wide_rows();
		test_tall_frame();
		test_rounding_ties();
		test_saturation();
		test_geometry_clamp();
		test_midframe_resize();
		test_random_frames();
		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d pixel beats, checked %0d results over %0d frames.",
			pixels_sent, results_seen, frames_done);
		$display("Covered long rows, tall narrow frames, rounding ties, saturation, %s",
			"clamped and mid-frame geometry, and long output holds.");
		if (errors == 0 && expected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
